// File: hw/rtl/lpmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest prefix match table: shared package
// Request codes and the records passed along the cell chain.
// ----------------------------------------------------------------------------
package lpmt_pkg;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	localparam int ADDR_W = 32;
	localparam int PORT_W = 4;
	localparam int SLOT_W = 4;

	// Search record walking through the cells, one cell per cycle unless stalled.
	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] gateway;
		logic [PORT_W-1:0] port;
		logic [SLOT_W-1:0] slot;
	} token_t;

	// Route written into one cell.
	typedef struct packed {
		logic              used;
		logic [ADDR_W-1:0] prefix;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] gateway;
		logic [PORT_W-1:0] port;
	} route_t;

endpackage

// File: hw/rtl/lpmt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest prefix match table: request channel
// Valid/ready channel carrying route writes and address lookups.
// ----------------------------------------------------------------------------
interface lpmt_req_if;

	logic        valid;
	logic        ready;
	logic        req_type;
	logic [3:0]  slot_index;
	logic        slot_valid;
	logic [31:0] entry_prefix;
	logic [31:0] entry_mask;
	logic [31:0] entry_gateway;
	logic [3:0]  entry_port;
	logic [31:0] lookup_address;

	modport source (
		output valid, req_type, slot_index, slot_valid, entry_prefix, entry_mask,
		       entry_gateway, entry_port, lookup_address,
		input  ready
	);

	modport sink (
		input  valid, req_type, slot_index, slot_valid, entry_prefix, entry_mask,
		       entry_gateway, entry_port, lookup_address,
		output ready
	);

endinterface

// File: hw/rtl/lpmt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest prefix match table: response channel
// Valid/ready channel carrying one lookup result per transaction.
// ----------------------------------------------------------------------------
interface lpmt_rsp_if;

	logic        valid;
	logic        ready;
	logic        hit;
	logic [31:0] next_hop;
	logic [3:0]  out_port;
	logic [3:0]  matched_slot;

	modport source (
		output valid, hit, next_hop, out_port, matched_slot,
		input  ready
	);

	modport sink (
		input  valid, hit, next_hop, out_port, matched_slot,
		output ready
	);

endinterface

// File: hw/rtl/longest_prefix_match_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest prefix match table: top level
// Route table: a row of cells a lookup walks one cell a cycle unless stalled.
// ----------------------------------------------------------------------------
// A route write returns nothing. A lookup is accepted only when no other
// lookup is in flight, then passes through the ENTRIES cells, one cell per
// clock while the chain is not stalled, and lands in the response register;
// the request channel opens again on that same edge, so a new lookup is
// taken only after the previous one has left the cell chain. A finished
// result may wait in the response register while a new request is accepted;
// the chain holds its record at the last cell only if the previous result
// has still not been taken. Writes to a slot at or above ENTRIES are
// dropped, and a stored port at or above PORTS is saturated to PORTS - 1.
module longest_prefix_match_table_core #(
	parameter int ENTRIES = 16,
	parameter int PORTS   = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	lpmt_req_if.sink   req,
	lpmt_rsp_if.source rsp
);

	logic [ENTRIES:0]     chain_vld;
	lpmt_pkg::token_t     chain_tok [ENTRIES+1];
	logic                 advance;
	logic                 req_acc;
	lpmt_pkg::route_t     wr_route;
	logic                 rsp_valid_q;
	logic                 hit_q;
	logic [31:0]          next_hop_q;
	logic [3:0]           out_port_q;
	logic [3:0]           matched_slot_q;

	assign req.ready = ~|chain_vld[ENTRIES:1];
	assign req_acc   = req.valid && req.ready;

	// Only one record is ever in the chain, so the whole chain stalls together.
	assign advance = !(chain_vld[ENTRIES] && rsp_valid_q && !rsp.ready);

	assign chain_vld[0]         = req_acc && (req.req_type == lpmt_pkg::REQ_LOOKUP);
	assign chain_tok[0].found   = 1'b0;
	assign chain_tok[0].addr    = req.lookup_address;
	assign chain_tok[0].mask    = '0;
	assign chain_tok[0].gateway = '0;
	assign chain_tok[0].port    = '0;
	assign chain_tok[0].slot    = '0;

	always_comb begin
		wr_route.used    = req.slot_valid;
		wr_route.prefix  = req.entry_prefix;
		wr_route.mask    = req.entry_mask;
		wr_route.gateway = req.entry_gateway;
		wr_route.port    = req.entry_port;
		if (int'(req.entry_port) >= PORTS) begin
			wr_route.port = lpmt_pkg::PORT_W'(PORTS - 1);
		end
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic wr_en;

		assign wr_en = req_acc && (req.req_type == lpmt_pkg::REQ_WRITE)
		               && (int'(req.slot_index) == i);

		lpmt_cell #(
			.INDEX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.wr_en     (wr_en),
			.wr_route  (wr_route),
			.in_valid  (chain_vld[i]),
			.in_token  (chain_tok[i]),
			.out_valid (chain_vld[i+1]),
			.out_token (chain_tok[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (chain_vld[ENTRIES] && advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// A miss leaves the record's zero initial values in place.
	always_ff @(posedge clk) begin
		if (chain_vld[ENTRIES] && advance) begin
			hit_q          <= chain_tok[ENTRIES].found;
			next_hop_q     <= chain_tok[ENTRIES].gateway;
			out_port_q     <= chain_tok[ENTRIES].port;
			matched_slot_q <= chain_tok[ENTRIES].slot;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.hit          = hit_q;
	assign rsp.next_hop     = next_hop_q;
	assign rsp.out_port     = out_port_q;
	assign rsp.matched_slot = matched_slot_q;

endmodule

// File: hw/rtl/lpmt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest prefix match table: route cell
// Holds one route slot and updates the passing search record with it.
// ----------------------------------------------------------------------------
module lpmt_cell #(
	parameter int INDEX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             wr_en,
	input  lpmt_pkg::route_t wr_route,
	input  logic             in_valid,
	input  lpmt_pkg::token_t in_token,
	output logic             out_valid,
	output lpmt_pkg::token_t out_token
);

	logic                                used_q;
	logic [lpmt_pkg::ADDR_W-1:0]         prefix_q;
	logic [lpmt_pkg::ADDR_W-1:0]         mask_q;
	logic [lpmt_pkg::ADDR_W-1:0]         gateway_q;
	logic [lpmt_pkg::PORT_W-1:0]         port_q;
	logic                                tok_valid_q;
	lpmt_pkg::token_t                    tok_q;
	logic                                match;
	logic                                better;
	lpmt_pkg::token_t                    tok_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (wr_en) begin
			used_q <= wr_route.used;
		end
	end

	// A clear only drops the used bit; the stored route is never read again.
	always_ff @(posedge clk) begin
		if (wr_en && wr_route.used) begin
			prefix_q  <= wr_route.prefix;
			mask_q    <= wr_route.mask;
			gateway_q <= wr_route.gateway;
			port_q    <= wr_route.port;
		end
	end

	// Strictly greater, so an earlier slot keeps the lead on equal masks.
	always_comb begin
		match    = used_q && ((prefix_q & mask_q) == (in_token.addr & mask_q));
		better   = match && (!in_token.found || (mask_q > in_token.mask));
		tok_next = in_token;
		if (better) begin
			tok_next.found   = 1'b1;
			tok_next.mask    = mask_q;
			tok_next.gateway = gateway_q;
			tok_next.port    = port_q;
			tok_next.slot    = lpmt_pkg::SLOT_W'(INDEX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (advance) begin
			tok_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_q <= tok_next;
		end
	end

	assign out_valid = tok_valid_q;
	assign out_token = tok_q;

endmodule

// File: hw/rtl/lpmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest prefix match table: port checker
// Concurrent checks on the request and response ports of the table.
// ----------------------------------------------------------------------------
module lpmt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_type,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        hit,
	input logic [31:0] next_hop,
	input logic [3:0]  out_port,
	input logic [3:0]  matched_slot
);

	// A response waiting to be taken stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
	else $error("response withdrawn before it was taken");

	// Once a lookup is taken the table is busy with it.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == lpmt_pkg::REQ_LOOKUP) |=> !req_ready)
	else $error("request taken while a lookup is in flight");

	// A route write never produces a response.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == lpmt_pkg::REQ_WRITE) && !rsp_valid
		|=> !rsp_valid)
	else $error("response appeared after a route write");

	// A miss reports all result fields as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !hit |-> (next_hop == '0) && (out_port == '0) && (matched_slot == '0))
	else $error("miss reported with non-zero result fields");

endmodule

bind longest_prefix_match_table_core lpmt_checker u_lpmt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_type     (req.req_type),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.hit          (rsp.hit),
	.next_hop     (rsp.next_hop),
	.out_port     (rsp.out_port),
	.matched_slot (rsp.matched_slot)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest prefix match table: testbench
// Drives route writes and address lookups through the request channel and
// checks every lookup result against a software copy of the route table.
// Both channels pause at random, except in the final stretch of the run.
// ----------------------------------------------------------------------------
module testbench;

	localparam int TABLE_SLOTS  = 16;
	localparam int TABLE_PORTS  = 16;
	localparam int RANDOM_ITEMS = 1000;
	localparam int TAIL_ITEMS   = 150;

	typedef struct {
		logic                        kind;
		logic [lpmt_pkg::SLOT_W-1:0] slot;
		logic                        store;
		logic [lpmt_pkg::ADDR_W-1:0] prefix;
		logic [lpmt_pkg::ADDR_W-1:0] mask;
		logic [lpmt_pkg::ADDR_W-1:0] gateway;
		logic [lpmt_pkg::PORT_W-1:0] port;
		logic [lpmt_pkg::ADDR_W-1:0] addr;
	} route_req_t;

	typedef struct {
		logic                        hit;
		logic [lpmt_pkg::ADDR_W-1:0] next_hop;
		logic [lpmt_pkg::PORT_W-1:0] out_port;
		logic [lpmt_pkg::SLOT_W-1:0] matched_slot;
	} lookup_result_t;

	logic clk;
	logic arst_n;

	lpmt_req_if req_ch ();
	lpmt_rsp_if rsp_ch ();

	longest_prefix_match_table_core #(
		.ENTRIES(TABLE_SLOTS),
		.PORTS  (TABLE_PORTS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	route_req_t     pending_reqs[$];
	lookup_result_t expected_routes[$];
	int             total_reqs;
	int             accepted_reqs = 0;
	int             failures = 0;
	logic           gaps_on = 1'b1;
	int             req_gap;
	int             rsp_stall;

	// Software copy of the route table, updated as each route write is accepted.
	bit                          tbl_used[TABLE_SLOTS];
	logic [lpmt_pkg::ADDR_W-1:0] tbl_prefix[TABLE_SLOTS];
	logic [lpmt_pkg::ADDR_W-1:0] tbl_mask[TABLE_SLOTS];
	logic [lpmt_pkg::ADDR_W-1:0] tbl_gateway[TABLE_SLOTS];
	logic [lpmt_pkg::PORT_W-1:0] tbl_port[TABLE_SLOTS];

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic route_req_t write_req(logic [3:0] slot, logic store,
			logic [31:0] prefix, logic [31:0] mask, logic [31:0] gateway,
			logic [3:0] port);
		route_req_t r;
		r.kind    = lpmt_pkg::REQ_WRITE;
		r.slot    = slot;
		r.store   = store;
		r.prefix  = prefix;
		r.mask    = mask;
		r.gateway = gateway;
		r.port    = port;
		r.addr    = $urandom;
		return r;
	endfunction

	function automatic route_req_t lookup_req(logic [31:0] addr);
		route_req_t r;
		r.kind    = lpmt_pkg::REQ_LOOKUP;
		r.slot    = lpmt_pkg::SLOT_W'($urandom_range(0, 15));
		r.store   = 1'($urandom_range(0, 1));
		r.prefix  = $urandom;
		r.mask    = $urandom;
		r.gateway = $urandom;
		r.port    = lpmt_pkg::PORT_W'($urandom_range(0, 15));
		r.addr    = addr;
		return r;
	endfunction

	function automatic void apply_route_write(route_req_t r);
		logic [lpmt_pkg::PORT_W-1:0] port;
		port = r.port;
		if (int'(r.slot) < TABLE_SLOTS) begin
			if (r.store) begin
				if (int'(port) >= TABLE_PORTS)
					port = lpmt_pkg::PORT_W'(TABLE_PORTS - 1);
				tbl_used[r.slot]    = 1'b1;
				tbl_prefix[r.slot]  = r.prefix;
				tbl_mask[r.slot]    = r.mask;
				tbl_gateway[r.slot] = r.gateway;
				tbl_port[r.slot]    = port;
			end else begin
				tbl_used[r.slot] = 1'b0;
			end
		end
	endfunction

	// The longest mask wins; scanning upward with a strict compare keeps the
	// lowest slot on equal masks.
	function automatic lookup_result_t best_route(logic [lpmt_pkg::ADDR_W-1:0] addr);
		lookup_result_t r;
		bit             found;
		int             best;
		found          = 1'b0;
		best           = 0;
		r.hit          = 1'b0;
		r.next_hop     = '0;
		r.out_port     = '0;
		r.matched_slot = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (tbl_used[i]
			    && ((tbl_prefix[i] & tbl_mask[i]) == (addr & tbl_mask[i]))) begin
				if (!found || tbl_mask[i] > tbl_mask[best]) begin
					found = 1'b1;
					best  = i;
				end
			end
		end
		if (found) begin
			r.hit          = 1'b1;
			r.next_hop     = tbl_gateway[best];
			r.out_port     = tbl_port[best];
			r.matched_slot = lpmt_pkg::SLOT_W'(best);
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			failures++;
		end
	endtask

	// Bursts of idling are switched on and off at random and stay off for
	// the final stretch of requests.
	always @(posedge clk) begin
		if (pending_reqs.size() < TAIL_ITEMS)
			gaps_on <= 1'b0;
		else if ($urandom_range(0, 47) == 0)
			gaps_on <= !gaps_on;
	end

	always @(posedge clk or negedge arst_n) begin : req_driver
		route_req_t item;
		if (!arst_n) begin
			req_ch.valid          <= 1'b0;
			req_ch.req_type       <= lpmt_pkg::REQ_WRITE;
			req_ch.slot_index     <= '0;
			req_ch.slot_valid     <= 1'b0;
			req_ch.entry_prefix   <= '0;
			req_ch.entry_mask     <= '0;
			req_ch.entry_gateway  <= '0;
			req_ch.entry_port     <= '0;
			req_ch.lookup_address <= '0;
			req_gap               <= 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_gap != 0) begin
				req_ch.valid <= 1'b0;
				req_gap      <= req_gap - 1;
			end else if (gaps_on && $urandom_range(0, 3) == 0) begin
				req_ch.valid <= 1'b0;
				req_gap      <= $urandom_range(0, 4);
			end else if (pending_reqs.size() != 0) begin
				item = pending_reqs.pop_front();
				req_ch.valid          <= 1'b1;
				req_ch.req_type       <= item.kind;
				req_ch.slot_index     <= item.slot;
				req_ch.slot_valid     <= item.store;
				req_ch.entry_prefix   <= item.prefix;
				req_ch.entry_mask     <= item.mask;
				req_ch.entry_gateway  <= item.gateway;
				req_ch.entry_port     <= item.port;
				req_ch.lookup_address <= item.addr;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall    <= 0;
		end else if (rsp_stall != 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall    <= rsp_stall - 1;
		end else if (gaps_on && $urandom_range(0, 4) == 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall    <= $urandom_range(0, 4);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// The result is checked before the request of the same edge is taken in;
	// a lookup accepted now cannot have its result on this edge.
	always @(posedge clk) begin : monitor
		lookup_result_t want;
		route_req_t     seen;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_routes.size() == 0) begin
					$display("%0t: result with none expected, actual hit %b next_hop %h port %h slot %h",
						$time, rsp_ch.hit, rsp_ch.next_hop, rsp_ch.out_port, rsp_ch.matched_slot);
					failures++;
				end else begin
					want = expected_routes.pop_front();
					check_field("hit", 32'(want.hit), 32'(rsp_ch.hit));
					check_field("next_hop", want.next_hop, rsp_ch.next_hop);
					check_field("out_port", 32'(want.out_port), 32'(rsp_ch.out_port));
					check_field("matched_slot", 32'(want.matched_slot), 32'(rsp_ch.matched_slot));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				accepted_reqs++;
				if (req_ch.req_type == lpmt_pkg::REQ_LOOKUP) begin
					expected_routes.push_back(best_route(req_ch.lookup_address));
				end else begin
					seen.kind    = req_ch.req_type;
					seen.slot    = req_ch.slot_index;
					seen.store   = req_ch.slot_valid;
					seen.prefix  = req_ch.entry_prefix;
					seen.mask    = req_ch.entry_mask;
					seen.gateway = req_ch.entry_gateway;
					seen.port    = req_ch.entry_port;
					seen.addr    = req_ch.lookup_address;
					apply_route_write(seen);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		bit          gen_written[TABLE_SLOTS];
		logic [31:0] gen_prefix[TABLE_SLOTS];
		logic [31:0] gen_mask[TABLE_SLOTS];
		route_req_t  r;
		int          s;
		int          len;
		logic [31:0] mask;
		logic [31:0] prefix;
		logic [31:0] addr;

		arst_n = 1'b0;
		foreach (gen_written[i])
			gen_written[i] = 1'b0;

		// Directed part: empty table, default route, nested prefixes, a tie on
		// equal masks, a host route, a non-contiguous mask and cleared slots.
		pending_reqs.push_back(lookup_req(32'h0000_0000));
		pending_reqs.push_back(lookup_req(32'hFFFF_FFFF));
		pending_reqs.push_back(write_req(4'd0, 1'b1, 32'h0000_0000, 32'h0000_0000,
			32'hFFFF_FFFF, 4'd15));
		pending_reqs.push_back(lookup_req(32'h1234_5678));
		pending_reqs.push_back(write_req(4'd15, 1'b1, 32'h0A00_0000, 32'hFF00_0000,
			32'h0A00_0001, 4'd0));
		pending_reqs.push_back(write_req(4'd7, 1'b1, 32'h0A01_0000, 32'hFFFF_0000,
			32'h0A01_0001, 4'd1));
		pending_reqs.push_back(write_req(4'd3, 1'b1, 32'h0A01_FFFF, 32'hFFFF_0000,
			32'h0A01_0002, 4'd2));
		pending_reqs.push_back(lookup_req(32'h0A01_FFFF));
		pending_reqs.push_back(lookup_req(32'h0AFF_FFFF));
		pending_reqs.push_back(write_req(4'd9, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h0000_0000, 4'd0));
		pending_reqs.push_back(lookup_req(32'hFFFF_FFFF));
		pending_reqs.push_back(lookup_req(32'hFFFF_FFFE));
		pending_reqs.push_back(write_req(4'd12, 1'b1, 32'hA0B0_C0D0, 32'hF0F0_F0F0,
			32'h5555_AAAA, 4'd5));
		pending_reqs.push_back(lookup_req(32'hA5B5_C5D5));
		pending_reqs.push_back(write_req(4'd3, 1'b0, $urandom, $urandom, $urandom, 4'd9));
		pending_reqs.push_back(lookup_req(32'h0A01_1234));
		pending_reqs.push_back(write_req(4'd0, 1'b0, $urandom, $urandom, $urandom, 4'd6));
		pending_reqs.push_back(lookup_req(32'h1234_5678));
		pending_reqs.push_back(write_req(4'd3, 1'b1, 32'hC0A8_0100, 32'hFFFF_FF00,
			32'hC0A8_0101, 4'd10));
		pending_reqs.push_back(lookup_req(32'hC0A8_01FF));
		pending_reqs.push_back(lookup_req(32'hC0A8_02FF));

		// Random part: up to half of the writes nest under routes already placed and most
		// lookups fall inside a stored prefix, so hits and ties are common.
		repeat (RANDOM_ITEMS) begin
			s = $urandom_range(0, TABLE_SLOTS - 1);
			if ($urandom_range(0, 9) < 4) begin
				len = $urandom_range(0, 99);
				if (len < 10)
					mask = $urandom;
				else if (len < 15)
					mask = 32'h0000_0000;
				else
					mask = 32'hFFFF_FFFF << (32 - $urandom_range(1, 32));
				prefix = $urandom;
				if (gen_written[s] && $urandom_range(0, 1) == 1)
					prefix = (gen_prefix[s] & gen_mask[s]) | ($urandom & ~gen_mask[s]);
				r = write_req(4'($urandom_range(0, 15)), $urandom_range(0, 99) >= 15,
					prefix, mask, $urandom, 4'($urandom_range(0, 15)));
				if (r.store) begin
					gen_written[r.slot] = 1'b1;
					gen_prefix[r.slot]  = r.prefix;
					gen_mask[r.slot]    = r.mask;
				end
			end else begin
				addr = $urandom;
				if (gen_written[s] && $urandom_range(0, 9) < 7)
					addr = (gen_prefix[s] & gen_mask[s]) | (addr & ~gen_mask[s]);
				r = lookup_req(addr);
			end
			pending_reqs.push_back(r);
		end
		total_reqs = pending_reqs.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_reqs != total_reqs)
			@(posedge clk);
		while (expected_routes.size() != 0)
			@(posedge clk);
		repeat (2 * TABLE_SLOTS + 10) @(posedge clk);

		if (failures == 0 && expected_routes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
